/* design/rem_pkg.sv */
// Shared types, codes and sizes for the relational event feature engine.
package rem_pkg;

    localparam int ACTORS    = 64;
    localparam int ACT_BITS  = 6;
    localparam int PAIR_BITS = 2 * ACT_BITS;
    localparam int TIME_W    = 32;
    localparam int CNT_W     = 32;
    localparam int FEN_W     = 4;

    localparam logic [2:0] KIND_DYAD   = 3'd0;
    localparam logic [2:0] KIND_TRANS  = 3'd1;
    localparam logic [2:0] KIND_CYCLIC = 3'd2;
    localparam logic [2:0] KIND_SBAL   = 3'd3;
    localparam logic [2:0] KIND_RBAL   = 3'd4;

    localparam logic [1:0] FAM_TRANS  = 2'd0;
    localparam logic [1:0] FAM_CYCLIC = 2'd1;
    localparam logic [1:0] FAM_SBAL   = 2'd2;
    localparam logic [1:0] FAM_RBAL   = 2'd3;

    localparam logic [2:0] FAM_KIND [4] = '{KIND_TRANS, KIND_CYCLIC, KIND_SBAL, KIND_RBAL};

    localparam logic [FEN_W-1:0] FEN_RESET = 4'hF;

    typedef struct packed {
        logic [ACT_BITS-1:0] sender;
        logic [ACT_BITS-1:0] receiver;
        logic [TIME_W-1:0]   event_time;
    } event_t;

    typedef struct packed {
        logic [2:0]        kind;
        logic [CNT_W-1:0]  sender_degree;
        logic [CNT_W-1:0]  receiver_degree;
        logic [CNT_W-1:0]  pair_count;
        logic [TIME_W-1:0] newest_age;
        logic [TIME_W-1:0] oldest_age;
        logic              age_valid;
        logic              last_of_event;
    } result_t;

    typedef struct packed {
        logic   empty;
        event_t item;
    } cmd_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD0,
        ST_RD1,
        ST_RD2,
        ST_RD3,
        ST_DYAD,
        ST_SCAN,
        ST_DRAIN,
        ST_EMIT,
        ST_UPD
    } state_t;

endpackage

/* design/rem_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module rem_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* design/rem_front.sv */
// Front end: accepts event items into a two-entry command queue.
module rem_front (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    output logic           full,
    input  rem_pkg::event_t event_item,
    output rem_pkg::cmd_t  cmd,
    input  logic           cmd_pop
);

    rem_pkg::event_t q_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       do_push, do_pop;

    assign full    = (cnt_reg == 2'd2);
    assign do_push = push && !full;
    assign do_pop  = cmd_pop && (cnt_reg != 2'd0);

    // Advance pointers and fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ do_push;
        rd_ptr_next = rd_ptr_reg ^ do_pop;
        cnt_next    = cnt_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Store the accepted item
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            q_reg[wr_ptr_reg] <= event_item;
        end
    end

    assign cmd.empty = (cnt_reg == 2'd0);
    assign cmd.item  = q_reg[rd_ptr_reg];

endmodule

/* design/rem_back.sv */
// Back end: reads the actor and pair tables, scans triads, emits results, updates state.
module rem_back (
    input  logic                            clk,
    input  logic                            rst_n,
    input  rem_pkg::cmd_t                   cmd,
    output logic                            cmd_pop,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [rem_pkg::FEN_W-1:0]       cfg_data,
    output logic                            empty,
    input  logic                            pop,
    output rem_pkg::result_t                result
);

    localparam int AB = rem_pkg::ACT_BITS;
    localparam int PB = rem_pkg::PAIR_BITS;
    localparam int TW = rem_pkg::TIME_W;
    localparam int CW = rem_pkg::CNT_W;
    localparam int NA = rem_pkg::ACTORS;

    rem_pkg::state_t state_reg, state_next;

    logic [rem_pkg::FEN_W-1:0] fen_reg, fen_next;
    logic [NA-1:0] sent_v_reg, sent_v_next;
    logic [NA-1:0] recv_v_reg, recv_v_next;
    logic [NA-1:0] outl_v_reg, outl_v_next;
    logic [NA-1:0] inl_v_reg, inl_v_next;
    logic [1:0]    fam_reg, fam_next;
    logic [AB-1:0] k_reg, k_next;
    logic          pend_reg, pend_next;
    logic [AB:0]   cnt_reg, cnt_next;

    logic [AB-1:0] s_reg, s_next, r_reg, r_next;
    logic [TW-1:0] t_reg, t_next;
    logic [NA-1:0] row_os_reg, row_os_next, row_or_reg, row_or_next;
    logic [NA-1:0] in_s_reg, in_s_next, in_r_reg, in_r_next;
    logic [CW-1:0] sent_reg, sent_next, recv_reg, recv_next;
    logic [CW-1:0] pev_sr_reg, pev_sr_next, pev_rs_reg, pev_rs_next;
    logic [TW-1:0] plast_reg, plast_next;
    logic [TW-1:0] fmax_reg, fmax_next, fmin_reg, fmin_next;

    // Output queue
    rem_pkg::result_t oq_reg [2];
    logic       owr_reg, owr_next, ord_reg, ord_next;
    logic [1:0] ocnt_reg, ocnt_next;
    logic       o_push, o_pop, o_full;
    rem_pkg::result_t o_data;

    // Memory ports
    logic [CW-1:0] sent_rd, recv_rd, pev_rd;
    logic [TW-1:0] plast_rd, pfa_rd, pfb_rd;
    logic [NA-1:0] outl_rd, inl_rd;
    logic [AB-1:0] outl_ra, inl_ra;
    logic [PB-1:0] pev_ra, pfa_ra, pfb_ra;
    logic          upd_we, first_we;

    // Scan signals
    logic          l1, l2, cand;
    logic [TW-1:0] f_cur;
    logic [3:0]    fen_above;
    logic [3:0]    fen_from_next;
    logic [1:0]    fam_first;
    logic [2:0]    fam_start;
    logic          pev_sr_valid, pev_rs_valid;

    rem_ram #(.WIDTH(CW), .DEPTH(NA)) u_sent (
        .clk(clk), .we(upd_we), .waddr(s_reg),
        .wdata((sent_reg == '1) ? sent_reg : sent_reg + 1'b1),
        .raddr(s_reg), .rdata(sent_rd));

    rem_ram #(.WIDTH(CW), .DEPTH(NA)) u_recv (
        .clk(clk), .we(upd_we), .waddr(r_reg),
        .wdata((recv_reg == '1) ? recv_reg : recv_reg + 1'b1),
        .raddr(r_reg), .rdata(recv_rd));

    rem_ram #(.WIDTH(CW), .DEPTH(NA * NA)) u_pev (
        .clk(clk), .we(upd_we), .waddr({s_reg, r_reg}),
        .wdata(!pev_sr_valid ? CW'(1) :
               ((pev_sr_reg == '1) ? pev_sr_reg : pev_sr_reg + 1'b1)),
        .raddr(pev_ra), .rdata(pev_rd));

    rem_ram #(.WIDTH(TW), .DEPTH(NA * NA)) u_plast (
        .clk(clk), .we(upd_we), .waddr({s_reg, r_reg}), .wdata(t_reg),
        .raddr({s_reg, r_reg}), .rdata(plast_rd));

    rem_ram #(.WIDTH(TW), .DEPTH(NA * NA)) u_pfa (
        .clk(clk), .we(first_we), .waddr({s_reg, r_reg}), .wdata(t_reg),
        .raddr(pfa_ra), .rdata(pfa_rd));

    rem_ram #(.WIDTH(TW), .DEPTH(NA * NA)) u_pfb (
        .clk(clk), .we(first_we), .waddr({s_reg, r_reg}), .wdata(t_reg),
        .raddr(pfb_ra), .rdata(pfb_rd));

    rem_ram #(.WIDTH(NA), .DEPTH(NA)) u_outl (
        .clk(clk), .we(upd_we), .waddr(s_reg),
        .wdata(row_os_reg | (NA'(1) << r_reg)),
        .raddr(outl_ra), .rdata(outl_rd));

    rem_ram #(.WIDTH(NA), .DEPTH(NA)) u_inl (
        .clk(clk), .we(upd_we), .waddr(r_reg),
        .wdata(in_r_reg | (NA'(1) << s_reg)),
        .raddr(inl_ra), .rdata(inl_rd));

    assign pev_sr_valid = row_os_reg[r_reg];
    assign pev_rs_valid = row_or_reg[s_reg];
    assign upd_we       = (state_reg == rem_pkg::ST_UPD);
    assign first_we     = upd_we && !pev_sr_valid;
    assign cfg_ready    = 1'b1;

    // Read addresses per sequencer step
    always_comb
    begin
        outl_ra = (state_reg == rem_pkg::ST_RD0) ? s_reg : r_reg;
        inl_ra  = (state_reg == rem_pkg::ST_RD1) ? s_reg : r_reg;
        pev_ra  = (state_reg == rem_pkg::ST_RD0) ? {s_reg, r_reg} : {r_reg, s_reg};
    end

    // Select the two legs of the current family for candidate k
    always_comb
    begin
        l1     = 1'b0;
        l2     = 1'b0;
        pfa_ra = {s_reg, k_reg};
        pfb_ra = {k_reg, r_reg};
        unique case (fam_reg)
            rem_pkg::FAM_TRANS:
            begin
                l1 = row_os_reg[k_reg];
                l2 = in_r_reg[k_reg];
                pfa_ra = {s_reg, k_reg};
                pfb_ra = {k_reg, r_reg};
            end
            rem_pkg::FAM_CYCLIC:
            begin
                l1 = row_or_reg[k_reg];
                l2 = in_s_reg[k_reg];
                pfa_ra = {r_reg, k_reg};
                pfb_ra = {k_reg, s_reg};
            end
            rem_pkg::FAM_SBAL:
            begin
                l1 = row_os_reg[k_reg];
                l2 = row_or_reg[k_reg];
                pfa_ra = {s_reg, k_reg};
                pfb_ra = {r_reg, k_reg};
            end
            rem_pkg::FAM_RBAL:
            begin
                l1 = in_s_reg[k_reg];
                l2 = in_r_reg[k_reg];
                pfa_ra = {k_reg, s_reg};
                pfb_ra = {k_reg, r_reg};
            end
            default:
            begin
                l1 = 1'b0;
                l2 = 1'b0;
            end
        endcase
        cand  = l1 && l2 && (k_reg != s_reg) && (k_reg != r_reg);
        f_cur = (pfa_rd > pfb_rd) ? pfa_rd : pfb_rd;
    end

    // Find enabled families at or above a start index
    always_comb
    begin
        fam_start     = (state_reg == rem_pkg::ST_DYAD) ? 3'd0 : ({1'b0, fam_reg} + 3'd1);
        fen_above     = fen_reg & (4'hF << fam_start);
        fen_from_next = fen_above;
        fam_first     = 2'd0;
        for (int i = 3; i >= 0; i--)
        begin
            if (fen_from_next[i])
            begin
                fam_first = 2'(i);
            end
        end
    end

    // Sequencer: next state, result assembly and captures
    always_comb
    begin
        state_next  = state_reg;
        fen_next    = fen_reg;
        sent_v_next = sent_v_reg;
        recv_v_next = recv_v_reg;
        outl_v_next = outl_v_reg;
        inl_v_next  = inl_v_reg;
        fam_next    = fam_reg;
        k_next      = k_reg;
        pend_next   = pend_reg;
        cnt_next    = cnt_reg;
        s_next      = s_reg;
        r_next      = r_reg;
        t_next      = t_reg;
        row_os_next = row_os_reg;
        row_or_next = row_or_reg;
        in_s_next   = in_s_reg;
        in_r_next   = in_r_reg;
        sent_next   = sent_reg;
        recv_next   = recv_reg;
        pev_sr_next = pev_sr_reg;
        pev_rs_next = pev_rs_reg;
        plast_next  = plast_reg;
        fmax_next   = fmax_reg;
        fmin_next   = fmin_reg;
        cmd_pop     = 1'b0;
        o_push      = 1'b0;
        o_data      = '0;

        if (cfg_valid)
        begin
            fen_next = cfg_data;
        end

        unique case (state_reg) inside
            rem_pkg::ST_IDLE:
            begin
                if (!cmd.empty)
                begin
                    cmd_pop    = 1'b1;
                    s_next     = cmd.item.sender;
                    r_next     = cmd.item.receiver;
                    t_next     = cmd.item.event_time;
                    state_next = rem_pkg::ST_RD0;
                end
            end
            rem_pkg::ST_RD0:
            begin
                state_next = rem_pkg::ST_RD1;
            end
            rem_pkg::ST_RD1:
            begin
                sent_next   = sent_v_reg[s_reg] ? sent_rd : '0;
                recv_next   = recv_v_reg[r_reg] ? recv_rd : '0;
                row_os_next = outl_v_reg[s_reg] ? outl_rd : '0;
                pev_sr_next = pev_rd;
                plast_next  = plast_rd;
                state_next  = rem_pkg::ST_RD2;
            end
            rem_pkg::ST_RD2:
            begin
                row_or_next = outl_v_reg[r_reg] ? outl_rd : '0;
                in_s_next   = inl_v_reg[s_reg] ? inl_rd : '0;
                pev_rs_next = pev_rd;
                state_next  = rem_pkg::ST_RD3;
            end
            rem_pkg::ST_RD3:
            begin
                in_r_next  = inl_v_reg[r_reg] ? inl_rd : '0;
                state_next = rem_pkg::ST_DYAD;
            end
            rem_pkg::ST_DYAD:
            begin
                o_data.kind            = rem_pkg::KIND_DYAD;
                o_data.sender_degree   = sent_reg;
                o_data.receiver_degree = recv_reg;
                o_data.pair_count      = pev_rs_valid ? pev_rs_reg : '0;
                o_data.age_valid       = pev_sr_valid;
                o_data.newest_age      = (pev_sr_valid && (t_reg > plast_reg)) ?
                                         (t_reg - plast_reg) : '0;
                o_data.last_of_event   = (fen_above == 4'd0);
                if (!o_full)
                begin
                    o_push = 1'b1;
                    if (fen_above == 4'd0)
                    begin
                        state_next = rem_pkg::ST_UPD;
                    end
                    else
                    begin
                        fam_next   = fam_first;
                        k_next     = '0;
                        pend_next  = 1'b0;
                        cnt_next   = '0;
                        state_next = rem_pkg::ST_SCAN;
                    end
                end
            end
            rem_pkg::ST_SCAN, rem_pkg::ST_DRAIN:
            begin
                // Fold in the formation time read for the previous candidate
                if (pend_reg)
                begin
                    if ((cnt_reg == '0) || (f_cur > fmax_reg))
                    begin
                        fmax_next = f_cur;
                    end
                    if ((cnt_reg == '0) || (f_cur < fmin_reg))
                    begin
                        fmin_next = f_cur;
                    end
                    cnt_next = cnt_reg + 1'b1;
                end
                if (state_reg == rem_pkg::ST_SCAN)
                begin
                    pend_next = cand;
                    k_next    = k_reg + 1'b1;
                    if (k_reg == '1)
                    begin
                        state_next = rem_pkg::ST_DRAIN;
                    end
                end
                else
                begin
                    pend_next  = 1'b0;
                    state_next = rem_pkg::ST_EMIT;
                end
            end
            rem_pkg::ST_EMIT:
            begin
                o_data.kind          = rem_pkg::FAM_KIND[fam_reg];
                o_data.pair_count    = CW'(cnt_reg);
                o_data.age_valid     = (cnt_reg != '0);
                o_data.newest_age    = ((cnt_reg != '0) && (t_reg > fmax_reg)) ?
                                       (t_reg - fmax_reg) : '0;
                o_data.oldest_age    = ((cnt_reg != '0) && (t_reg > fmin_reg)) ?
                                       (t_reg - fmin_reg) : '0;
                o_data.last_of_event = (fen_above == 4'd0);
                if (!o_full)
                begin
                    o_push = 1'b1;
                    if (fen_above == 4'd0)
                    begin
                        state_next = rem_pkg::ST_UPD;
                    end
                    else
                    begin
                        fam_next   = fam_first;
                        k_next     = '0;
                        pend_next  = 1'b0;
                        cnt_next   = '0;
                        state_next = rem_pkg::ST_SCAN;
                    end
                end
            end
            rem_pkg::ST_UPD:
            begin
                sent_v_next[s_reg] = 1'b1;
                recv_v_next[r_reg] = 1'b1;
                outl_v_next[s_reg] = 1'b1;
                inl_v_next[r_reg]  = 1'b1;
                state_next         = rem_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = rem_pkg::ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= rem_pkg::ST_IDLE;
            fen_reg    <= rem_pkg::FEN_RESET;
            sent_v_reg <= '0;
            recv_v_reg <= '0;
            outl_v_reg <= '0;
            inl_v_reg  <= '0;
            fam_reg    <= '0;
            k_reg      <= '0;
            pend_reg   <= 1'b0;
            cnt_reg    <= '0;
            owr_reg    <= 1'b0;
            ord_reg    <= 1'b0;
            ocnt_reg   <= 2'd0;
        end
        else
        begin
            state_reg  <= state_next;
            fen_reg    <= fen_next;
            sent_v_reg <= sent_v_next;
            recv_v_reg <= recv_v_next;
            outl_v_reg <= outl_v_next;
            inl_v_reg  <= inl_v_next;
            fam_reg    <= fam_next;
            k_reg      <= k_next;
            pend_reg   <= pend_next;
            cnt_reg    <= cnt_next;
            owr_reg    <= owr_next;
            ord_reg    <= ord_next;
            ocnt_reg   <= ocnt_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        s_reg      <= s_next;
        r_reg      <= r_next;
        t_reg      <= t_next;
        row_os_reg <= row_os_next;
        row_or_reg <= row_or_next;
        in_s_reg   <= in_s_next;
        in_r_reg   <= in_r_next;
        sent_reg   <= sent_next;
        recv_reg   <= recv_next;
        pev_sr_reg <= pev_sr_next;
        pev_rs_reg <= pev_rs_next;
        plast_reg  <= plast_next;
        fmax_reg   <= fmax_next;
        fmin_reg   <= fmin_next;
        if (o_push)
        begin
            oq_reg[owr_reg] <= o_data;
        end
    end

    // Output queue pointers
    assign o_full = (ocnt_reg == 2'd2);
    assign o_pop  = pop && (ocnt_reg != 2'd0);
    always_comb
    begin
        owr_next  = owr_reg ^ o_push;
        ord_next  = ord_reg ^ o_pop;
        ocnt_next = ocnt_reg + {1'b0, o_push} - {1'b0, o_pop};
    end

    assign empty  = (ocnt_reg == 2'd0);
    assign result = oq_reg[ord_reg];

endmodule

/* design/relational_event_feature_engine.sv */
// Top level of the relational event feature engine.
// Usage: push an event (sender, receiver, event_time) while full is low; it is
// taken into a two-entry command queue. Results come out as a queue: while
// empty is low the oldest result sits on result, and pop takes it.
// Each event yields one dyadic result (kind 0) then one result per family set
// in family_enable; last_of_event marks the final one of the event.
// Configuration: cfg_data is written into family_enable when cfg_valid is high;
// cfg_ready is always high. Write it only while the block is idle.
// Scan: the sequencer handles one event at a time, and most of its work is the
// intermediary scan, which visits all 64 candidate actors per family and
// reads both first-time tables for each match, pipelined one actor a cycle.
// Reset: all counts, adjacency rows and degree tables read as zero at once
// through valid bits; family_enable returns to all four families.
// Stall: when the result queue fills, the sequencer holds on the pending
// result; the command queue keeps accepting until it too is full.
module relational_event_feature_engine (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      push,
    output logic                      full,
    input  rem_pkg::event_t           event_item,
    output logic                      empty,
    input  logic                      pop,
    output rem_pkg::result_t          result,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [rem_pkg::FEN_W-1:0] cfg_data
);

    rem_pkg::cmd_t cmd;
    logic          cmd_pop;

    rem_front u_front (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full),
        .event_item(event_item), .cmd(cmd), .cmd_pop(cmd_pop));

    rem_back u_back (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .cmd_pop(cmd_pop),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .empty(empty), .pop(pop), .result(result));

endmodule

/* test/relational_event_feature_engine_tb.sv */
// Testbench for the relational event feature engine: table-driven and random events checked against a predictor.
`timescale 1ns / 1ps

module relational_event_feature_engine_tb;

    localparam int SETTLE_CYCLES = 300;
    localparam int IDLE_LIMIT    = 20000;
    localparam int HOLD_CYCLES   = 2000;
    localparam int NACT          = rem_pkg::ACTORS;
    localparam logic [31:0] SAT  = 32'hFFFF_FFFF;

    logic                      clk;
    logic                      rst_n;
    logic                      push;
    logic                      full;
    rem_pkg::event_t           event_item;
    logic                      empty;
    logic                      pop;
    rem_pkg::result_t          result;
    logic                      cfg_valid;
    logic                      cfg_ready;
    logic [rem_pkg::FEN_W-1:0] cfg_data;

    relational_event_feature_engine uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .event_item (event_item),
        .empty      (empty),
        .pop        (pop),
        .result     (result),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data)
    );

    // Predictor state
    logic [rem_pkg::FEN_W-1:0] fam_mask;
    logic [31:0]       out_count [NACT];
    logic [31:0]       in_count [NACT];
    logic [31:0]       link_count [NACT*NACT];
    logic [31:0]       link_last [NACT*NACT];
    logic [31:0]       link_first [NACT*NACT];
    logic [NACT-1:0]   out_row [NACT];
    logic [NACT-1:0]   in_row [NACT];

    rem_pkg::result_t pending_results [$];
    int      failures;
    int      idle_cycles;
    bit      hold_off;
    bit      hold_req;
    int      hold_left;
    bit      finishing;

    // Directed table: typed-in expectation replaces the first result only
    typedef struct {
        rem_pkg::event_t  ev;
        bit               has_fixed;
        rem_pkg::result_t fixed;
    } row_t;

    always #10 clk = ~clk;

    function automatic logic [31:0] age(logic [31:0] now, logic [31:0] then);
        return (now > then) ? now - then : 32'd0;
    endfunction

    function automatic logic [31:0] bump(logic [31:0] v);
        return (v == SAT) ? v : v + 32'd1;
    endfunction

    // Append one expectation
    function automatic void expect_result(rem_pkg::result_t res);
        pending_results = {pending_results, res};
    endfunction

    // Count intermediaries of one triad family and their formation ages
    function automatic rem_pkg::result_t triad_stats(logic [2:0] kind, int s, int r,
                                                     logic [31:0] now);
        rem_pkg::result_t res;
        bit          l1, l2;
        int          i1, i2;
        logic [31:0] f, fmin, fmax, cnt;
        res = '0;
        res.kind = kind;
        cnt = 0;
        fmin = 0;
        fmax = 0;
        for (int k = 0; k < NACT; k++)
        begin
            if (k == s || k == r)
                continue;
            case (kind)
                rem_pkg::KIND_TRANS:
                begin
                    l1 = out_row[s][k]; l2 = in_row[r][k];
                    i1 = s*NACT + k;  i2 = k*NACT + r;
                end
                rem_pkg::KIND_CYCLIC:
                begin
                    l1 = out_row[r][k]; l2 = in_row[s][k];
                    i1 = r*NACT + k;  i2 = k*NACT + s;
                end
                rem_pkg::KIND_SBAL:
                begin
                    l1 = out_row[s][k]; l2 = out_row[r][k];
                    i1 = s*NACT + k;  i2 = r*NACT + k;
                end
                default:
                begin
                    l1 = in_row[s][k]; l2 = in_row[r][k];
                    i1 = k*NACT + s; i2 = k*NACT + r;
                end
            endcase
            if (!(l1 && l2))
                continue;
            f = (link_first[i1] > link_first[i2]) ? link_first[i1] : link_first[i2];
            if (cnt == 0 || f > fmax) fmax = f;
            if (cnt == 0 || f < fmin) fmin = f;
            cnt++;
        end
        if (cnt > 0)
        begin
            res.pair_count = cnt;
            res.newest_age = age(now, fmax);
            res.oldest_age = age(now, fmin);
            res.age_valid  = 1'b1;
        end
        return res;
    endfunction

    // Queue the results of one event, then advance the state
    function automatic int predict_event(rem_pkg::event_t ev);
        rem_pkg::result_t res;
        int      s, r, sr, n;
        s  = ev.sender;
        r  = ev.receiver;
        sr = s*NACT + r;
        n  = 0;
        res = '0;
        res.kind            = rem_pkg::KIND_DYAD;
        res.sender_degree   = out_count[s];
        res.receiver_degree = in_count[r];
        res.pair_count      = link_count[r*NACT + s];
        if (link_count[sr] > 0)
        begin
            res.newest_age = age(ev.event_time, link_last[sr]);
            res.age_valid  = 1'b1;
        end
        res.last_of_event = (fam_mask == 0);
        expect_result(res);
        for (int fam = 0; fam < 4; fam++)
        begin
            if (!fam_mask[fam])
                continue;
            res = triad_stats(rem_pkg::FAM_KIND[fam], s, r, ev.event_time);
            res.last_of_event = ((fam_mask >> (fam + 1)) == 0);
            expect_result(res);
            n++;
        end
        out_count[s] = bump(out_count[s]);
        in_count[r]  = bump(in_count[r]);
        if (link_count[sr] == 0)
            link_first[sr] = ev.event_time;
        link_count[sr] = bump(link_count[sr]);
        link_last[sr]  = ev.event_time;
        out_row[s][r]  = 1'b1;
        in_row[r][s]   = 1'b1;
        return n + 1;
    endfunction

    task automatic clear_model();
        fam_mask = rem_pkg::FEN_RESET;
        for (int a = 0; a < NACT; a++)
        begin
            out_count[a] = 0;
            in_count[a]  = 0;
            out_row[a]   = '0;
            in_row[a]    = '0;
        end
        for (int p = 0; p < NACT*NACT; p++)
        begin
            link_count[p] = 0;
            link_last[p]  = 0;
            link_first[p] = 0;
        end
    endtask

    // Offer one item and hold it until the block takes it
    task automatic send_event(rem_pkg::event_t ev);
        push       <= 1'b1;
        event_item <= ev;
        @(posedge clk);
        while (full)
            @(posedge clk);
        void'(predict_event(ev));
    endtask

    task automatic stop_push();
        push <= 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_mask(logic [rem_pkg::FEN_W-1:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        fam_mask = v;
    endtask

    // Random event: mostly on a small actor set so triads actually close
    function automatic rem_pkg::event_t rand_event(ref logic [31:0] clock_now);
        rem_pkg::event_t ev;
        int     pick;
        pick = $urandom_range(0, 9);
        if (pick < 7)
        begin
            ev.sender   = $urandom_range(0, 7);
            ev.receiver = $urandom_range(0, 7);
        end
        else
        begin
            ev.sender   = $urandom_range(0, 63);
            ev.receiver = $urandom_range(0, 63);
        end
        pick = $urandom_range(0, 19);
        if (pick == 0)
            ev.event_time = $urandom;
        else if (pick == 1)
            ev.event_time = clock_now - $urandom_range(0, 50);
        else
        begin
            clock_now = clock_now + $urandom_range(0, 40);
            ev.event_time = clock_now;
        end
        return ev;
    endfunction

    // Receiver hold-off: once requested, stall pops for a fixed stretch
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            hold_off  <= 1'b0;
            hold_left <= 0;
        end
        else if (hold_req)
        begin
            hold_off  <= 1'b1;
            hold_left <= HOLD_CYCLES;
        end
        else if (hold_left > 1)
            hold_left <= hold_left - 1;
        else
        begin
            hold_off  <= 1'b0;
            hold_left <= 0;
        end
    end

    // Receiver: pops on its own pattern, with a long hold-off on request
    always @(posedge clk)
    begin
        if (!rst_n)
            pop <= 1'b0;
        else if (hold_off)
            pop <= 1'b0;
        else if (($urandom_range(0, 63) < 4) && !finishing)
            pop <= 1'b0;
        else
            pop <= ($urandom_range(0, 3) != 0) || finishing;
    end

    // Check each accepted result against the oldest expectation
    always @(posedge clk)
    begin
        rem_pkg::result_t want;
        if (rst_n && pop && !empty)
        begin
            if (pending_results.size() == 0)
            begin
                $error("unexpected result kind=%0d", result.kind);
                failures++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (result.kind !== want.kind)
                begin
                    $error("kind exp %0d got %0d", want.kind, result.kind); failures++;
                end
                if (result.sender_degree !== want.sender_degree)
                begin
                    $error("sender_degree exp %0d got %0d", want.sender_degree,
                           result.sender_degree); failures++;
                end
                if (result.receiver_degree !== want.receiver_degree)
                begin
                    $error("receiver_degree exp %0d got %0d", want.receiver_degree,
                           result.receiver_degree); failures++;
                end
                if (result.pair_count !== want.pair_count)
                begin
                    $error("pair_count exp %0d got %0d", want.pair_count,
                           result.pair_count); failures++;
                end
                if (result.newest_age !== want.newest_age)
                begin
                    $error("newest_age exp %0d got %0d", want.newest_age,
                           result.newest_age); failures++;
                end
                if (result.oldest_age !== want.oldest_age)
                begin
                    $error("oldest_age exp %0d got %0d", want.oldest_age,
                           result.oldest_age); failures++;
                end
                if (result.age_valid !== want.age_valid)
                begin
                    $error("age_valid exp %0d got %0d", want.age_valid,
                           result.age_valid); failures++;
                end
                if (result.last_of_event !== want.last_of_event)
                begin
                    $error("last_of_event exp %0d got %0d", want.last_of_event,
                           result.last_of_event); failures++;
                end
            end
        end
    end

    // Watchdog: count cycles in which nothing moves
    always @(posedge clk)
    begin
        if ((push && !full) || (pop && !empty) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin
        row_t        rows [$];
        row_t        rw;
        logic [31:0] clock_now;
        rem_pkg::event_t ev;
        int          burst;
        logic [rem_pkg::FEN_W-1:0] masks [5];

        clk = 1'b0;
        rst_n = 1'b0;
        push = 1'b0;
        event_item = '0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        failures = 0;
        idle_cycles = 0;
        hold_req = 1'b0;
        finishing = 1'b0;
        clear_model();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed rows: extremes, self event, time backwards, triads
        rw.ev        = '{6'd0, 6'd63, 32'd0};
        rw.has_fixed = 1;
        rw.fixed     = '0;
        rw.fixed.kind = rem_pkg::KIND_DYAD;
        rows = {rows, rw};
        rw.has_fixed = 0;
        rw.fixed     = '0;
        rw.ev = '{6'd63, 6'd0, 32'hFFFF_FFFF};       rows = {rows, rw};
        rw.ev = '{6'd0, 6'd63, 32'd10};              rows = {rows, rw};
        rw.ev = '{6'd5, 6'd5, 32'd20};               rows = {rows, rw};
        rw.ev = '{6'd5, 6'd5, 32'd25};               rows = {rows, rw};
        rw.ev = '{6'd1, 6'd2, 32'd30};               rows = {rows, rw};
        rw.ev = '{6'd2, 6'd3, 32'd40};               rows = {rows, rw};
        rw.ev = '{6'd1, 6'd3, 32'd50};               rows = {rows, rw};
        rw.ev = '{6'd3, 6'd1, 32'd60};               rows = {rows, rw};
        rw.ev = '{6'd4, 6'd2, 32'd70};               rows = {rows, rw};
        rw.ev = '{6'd1, 6'd4, 32'd80};               rows = {rows, rw};
        rw.ev = '{6'd1, 6'd3, 32'd5};                rows = {rows, rw};
        rw.ev = '{6'd42, 6'd21, 32'hAAAA_5555};      rows = {rows, rw};
        rw.ev = '{6'd21, 6'd42, 32'h5555_AAAA};      rows = {rows, rw};
        rw.ev = '{6'd3, 6'd1, 32'hFFFF_FFFF};        rows = {rows, rw};
        foreach (rows[i])
        begin
            if (rows[i].has_fixed)
            begin
                send_event(rows[i].ev);
                pending_results[pending_results.size() - 5] = rows[i].fixed;
            end
            else
                send_event(rows[i].ev);
        end
        stop_push();
        wait_drained();

        // Random phases across family masks, extremes included
        masks = '{4'h0, 4'hF, 4'h5, 4'hA, 4'h8};
        clock_now = 32'd100;
        for (int ph = 0; ph < 5; ph++)
        begin
            write_mask(masks[ph]);
            for (int n = 0; n < 24; )
            begin
                burst = $urandom_range(1, 6);
                for (int b = 0; b < burst && n < 24; b++, n++)
                begin
                    ev = rand_event(clock_now);
                    send_event(ev);
                end
                stop_push();
                repeat ($urandom_range(1, 30)) @(posedge clk);
                if (ph == 1 && n >= 6 && n < 12)
                begin
                    // Hold off the receiver long enough for both queues to fill
                    hold_req <= 1'b1;
                    @(posedge clk);
                    hold_req <= 1'b0;
                    for (int j = 0; j < 6; j++)
                    begin
                        ev = rand_event(clock_now);
                        send_event(ev);
                        n++;
                    end
                    stop_push();
                    @(posedge clk);
                    while (hold_off)
                        @(posedge clk);
                end
                if (ph == 2 && n >= 12 && n < 18)
                    wait_drained();
            end
            stop_push();
            wait_drained();
        end

        finishing = 1'b1;
        wait_drained();
        if (failures == 0 && pending_results.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
